// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the ddsf_checker bind file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ddsf_pkg.sv =====
package ddsf_pkg;

    localparam int DEFAULT_TIME_WIDTH = 32;
    localparam int FIELD_W            = 16;
    localparam int CFG_DATA_W         = 16;
    localparam int CFG_INDEX_W        = 2;

    localparam int CMD_MAX      = 100;
    localparam int THROTTLE_MAX = 100;

    // floor(m / 100) == (m * 10486) >> 20 for every m up to 100 * 100
    localparam int          RECIP_SHIFT = 20;
    localparam logic [13:0] RECIP       = 14'd10486;

    localparam logic [6:0] DEADBAND_RST  = 7'd0;
    localparam logic [7:0] SLEW_STEP_RST = 8'd5;
    localparam logic [7:0] SLEW_STOP_RST = 8'd10;
    localparam logic [15:0] TIMEOUT_RST  = 16'd500;

    typedef logic signed [7:0]  cmd_t;
    typedef logic signed [14:0] prod_t;

    typedef enum logic
    {
        KIND_DRIVE = 1'b0,
        KIND_TICK  = 1'b1
    } kind_t;

    typedef enum logic [CFG_INDEX_W-1:0]
    {
        REG_DEADBAND  = 2'd0,
        REG_SLEW_STEP = 2'd1,
        REG_SLEW_STOP = 2'd2,
        REG_TIMEOUT   = 2'd3
    } reg_idx_t;

    typedef struct packed
    {
        logic [6:0] deadband;
        logic [7:0] step;
        logic [7:0] step_stop;
        logic       force_zero;
    } slew_ctrl_t;

    // Signed product / 100, truncated toward zero.
    function automatic cmd_t scale_cmd(input prod_t p);
        logic [13:0] mag;
        logic [27:0] q_full;
        logic [7:0]  q;
        mag    = p[14] ? 14'(-p) : p[13:0];
        q_full = mag * RECIP;
        q      = {1'b0, q_full[RECIP_SHIFT +: 7]};
        return p[14] ? cmd_t'(-q) : cmd_t'(q);
    endfunction

endpackage

// ===== hw/rtl/ddsf_mix.sv =====
module ddsf_mix
(
    input  logic signed [ddsf_pkg::FIELD_W-1:0] steer,
    input  logic signed [ddsf_pkg::FIELD_W-1:0] forward,
    input  logic signed [ddsf_pkg::FIELD_W-1:0] throttle,
    output ddsf_pkg::prod_t                     left_prod,
    output ddsf_pkg::prod_t                     right_prod
);
    import ddsf_pkg::*;

    function automatic cmd_t clamp_in(input logic signed [FIELD_W-1:0] v);
        cmd_t r;
        if (v > FIELD_W'(CMD_MAX))
            r = cmd_t'(CMD_MAX);
        else if (v < -FIELD_W'(CMD_MAX))
            r = cmd_t'(-CMD_MAX);
        else
            r = v[7:0];
        return r;
    endfunction

    function automatic cmd_t clamp_sum(input logic signed [8:0] v);
        cmd_t r;
        if (v > 9'sd100)
            r = cmd_t'(CMD_MAX);
        else if (v < -9'sd100)
            r = cmd_t'(-CMD_MAX);
        else
            r = v[7:0];
        return r;
    endfunction

    cmd_t                x;
    cmd_t                y;
    logic [6:0]          t;
    logic signed [8:0]   sum_l;
    logic signed [8:0]   sum_r;
    cmd_t                l;
    cmd_t                r;
    logic signed [15:0]  pl;
    logic signed [15:0]  pr;

    always_comb
    begin
        x = clamp_in(steer);
        y = clamp_in(forward);
        if (throttle[FIELD_W-1])
            t = 7'd0;
        else if (throttle > FIELD_W'(THROTTLE_MAX))
            t = 7'(THROTTLE_MAX);
        else
            t = throttle[6:0];
        sum_l = {y[7], y} + {x[7], x};
        sum_r = {y[7], y} - {x[7], x};
        l     = clamp_sum(sum_l);
        r     = clamp_sum(sum_r);
        pl    = l * $signed({1'b0, t});
        pr    = r * $signed({1'b0, t});
    end

    // |product| <= 10000 fits in 15 bits signed
    assign left_prod  = pl[14:0];
    assign right_prod = pr[14:0];

endmodule

// ===== hw/rtl/ddsf_slew.sv =====
module ddsf_slew
(
    input  ddsf_pkg::cmd_t       cur,
    input  ddsf_pkg::cmd_t       cmd,
    input  ddsf_pkg::slew_ctrl_t ctrl,
    output ddsf_pkg::cmd_t       nxt
);
    import ddsf_pkg::*;

    logic [7:0]        mag;
    cmd_t              tgt;
    logic signed [9:0] d;
    logic signed [9:0] lim;

    always_comb
    begin
        mag = cmd[7] ? 8'(-cmd) : 8'(cmd);
        if (ctrl.force_zero || (mag[6:0] < ctrl.deadband))
            tgt = '0;
        else
            tgt = cmd;

        lim = (tgt == '0) ? $signed({2'b00, ctrl.step_stop}) : $signed({2'b00, ctrl.step});
        d   = {{2{tgt[7]}}, tgt} - {{2{cur[7]}}, cur};
        if (d > lim)
            d = lim;
        else if (d < -lim)
            d = -lim;
        // moving toward an in-range target stays in range
        nxt = cur + d[7:0];
    end

endmodule

// ===== hw/rtl/differential_drive_slew_failsafe.sv =====
// A word accepted into the input register moves to the result register once
// that is free or being taken. Throughput: one word per cycle while out_ready
// holds; the input register and the result register form a two-stage pipeline,
// and state updates in the second stage.
// Reset (async, active low) clears state, commands, slewed outputs, failsafe and
// out_valid, and loads the register defaults; the result word is not reset.
module differential_drive_slew_failsafe
#(
    parameter int TIME_WIDTH = ddsf_pkg::DEFAULT_TIME_WIDTH
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,

    input  logic                                   cfg_we,
    input  logic [ddsf_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [ddsf_pkg::CFG_DATA_W-1:0]        cfg_data,

    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic                                   kind,
    input  logic signed [ddsf_pkg::FIELD_W-1:0]    steer,
    input  logic signed [ddsf_pkg::FIELD_W-1:0]    forward,
    input  logic signed [ddsf_pkg::FIELD_W-1:0]    throttle,
    input  logic [TIME_WIDTH-1:0]                  now_ms,

    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [7:0]                      left_speed,
    output logic signed [7:0]                      right_speed,
    output logic                                   changed,
    output logic                                   stopped
);
    import ddsf_pkg::*;

    // configuration
    logic [6:0]  deadband_reg;
    logic [7:0]  slew_step_reg;
    logic [7:0]  slew_stop_reg;
    logic [15:0] timeout_reg;

    // input stage
    logic                  s1_valid_reg;
    kind_t                 s1_kind_reg;
    logic [TIME_WIDTH-1:0] s1_now_reg;
    prod_t                 s1_left_prod_reg;
    prod_t                 s1_right_prod_reg;
    prod_t                 left_prod;
    prod_t                 right_prod;

    // block state
    cmd_t                  left_cmd_reg, left_cmd_next;
    cmd_t                  right_cmd_reg, right_cmd_next;
    cmd_t                  left_out_reg, left_out_next;
    cmd_t                  right_out_reg, right_out_next;
    logic [TIME_WIDTH-1:0] last_drive_reg, last_drive_next;
    logic                  failsafe_reg, failsafe_next;

    // result stage
    logic                  out_valid_reg, out_valid_next;
    cmd_t                  left_speed_reg, left_speed_next;
    cmd_t                  right_speed_reg, right_speed_next;
    logic                  changed_reg, changed_next;
    logic                  stopped_reg, stopped_next;

    logic                  adv;
    logic                  in_take;
    logic [TIME_WIDTH-1:0] elapsed;
    logic                  fs_tick;
    slew_ctrl_t            ctrl;
    cmd_t                  left_nxt;
    cmd_t                  right_nxt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadband_reg  <= DEADBAND_RST;
            slew_step_reg <= SLEW_STEP_RST;
            slew_stop_reg <= SLEW_STOP_RST;
            timeout_reg   <= TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_DEADBAND:  deadband_reg  <= cfg_data[6:0];
                REG_SLEW_STEP: slew_step_reg <= cfg_data[7:0];
                REG_SLEW_STOP: slew_stop_reg <= cfg_data[7:0];
                REG_TIMEOUT:   timeout_reg   <= cfg_data[15:0];
                default:       ;
            endcase
        end
    end

    ddsf_mix u_mix
    (
        .steer      (steer),
        .forward    (forward),
        .throttle   (throttle),
        .left_prod  (left_prod),
        .right_prod (right_prod)
    );

    assign adv      = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || adv;
    assign in_take  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_kind_reg       <= kind_t'(kind);
            s1_now_reg        <= now_ms;
            s1_left_prod_reg  <= left_prod;
            s1_right_prod_reg <= right_prod;
        end
    end

    // failsafe check uses the tick's own time stamp; elapsed wraps at TIME_WIDTH
    always_comb
    begin
        elapsed = s1_now_reg - last_drive_reg;
        fs_tick = failsafe_reg ||
                  ((timeout_reg != '0) && (elapsed > TIME_WIDTH'(timeout_reg)));
        ctrl.deadband   = deadband_reg;
        ctrl.step       = slew_step_reg;
        ctrl.step_stop  = slew_stop_reg;
        ctrl.force_zero = fs_tick;
    end

    ddsf_slew u_slew_l
    (
        .cur  (left_out_reg),
        .cmd  (left_cmd_reg),
        .ctrl (ctrl),
        .nxt  (left_nxt)
    );

    ddsf_slew u_slew_r
    (
        .cur  (right_out_reg),
        .cmd  (right_cmd_reg),
        .ctrl (ctrl),
        .nxt  (right_nxt)
    );

    always_comb
    begin
        left_cmd_next    = left_cmd_reg;
        right_cmd_next   = right_cmd_reg;
        left_out_next    = left_out_reg;
        right_out_next   = right_out_reg;
        last_drive_next  = last_drive_reg;
        failsafe_next    = failsafe_reg;
        left_speed_next  = left_speed_reg;
        right_speed_next = right_speed_reg;
        changed_next     = changed_reg;
        stopped_next     = stopped_reg;

        if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;

        if (adv)
        begin
            out_valid_next = 1'b1;
            case (s1_kind_reg)
                KIND_DRIVE:
                begin
                    left_cmd_next    = scale_cmd(s1_left_prod_reg);
                    right_cmd_next   = scale_cmd(s1_right_prod_reg);
                    last_drive_next  = s1_now_reg;
                    failsafe_next    = 1'b0;
                    left_speed_next  = left_out_reg;
                    right_speed_next = right_out_reg;
                    changed_next     = 1'b0;
                    stopped_next     = 1'b0;
                end
                KIND_TICK:
                begin
                    left_out_next    = left_nxt;
                    right_out_next   = right_nxt;
                    failsafe_next    = fs_tick;
                    left_speed_next  = left_nxt;
                    right_speed_next = right_nxt;
                    changed_next     = (left_nxt != left_out_reg) ||
                                       (right_nxt != right_out_reg);
                    stopped_next     = fs_tick;
                end
                default:
                begin
                    out_valid_next = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_cmd_reg   <= '0;
            right_cmd_reg  <= '0;
            left_out_reg   <= '0;
            right_out_reg  <= '0;
            last_drive_reg <= '0;
            failsafe_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            left_cmd_reg   <= left_cmd_next;
            right_cmd_reg  <= right_cmd_next;
            left_out_reg   <= left_out_next;
            right_out_reg  <= right_out_next;
            last_drive_reg <= last_drive_next;
            failsafe_reg   <= failsafe_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        left_speed_reg  <= left_speed_next;
        right_speed_reg <= right_speed_next;
        changed_reg     <= changed_next;
        stopped_reg     <= stopped_next;
    end

    assign out_valid   = out_valid_reg;
    assign left_speed  = left_speed_reg;
    assign right_speed = right_speed_reg;
    assign changed     = changed_reg;
    assign stopped     = stopped_reg;

endmodule

// ===== hw/rtl/ddsf_checker.sv =====
`include "assert_macros.svh"

module ddsf_checker
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic signed [7:0] left_speed,
    input logic signed [7:0] right_speed,
    input logic              changed,
    input logic              stopped
);

    // a stalled result word stays put
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result word dropped while stalled")
    `ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(left_speed) && $stable(right_speed) && $stable(changed) && $stable(stopped), "stalled result word changed")

    // input only backs up behind a held result
    `ASSERT_IMPLIES(a_stall_cause, clk, rst_n, in_valid && !in_ready, out_valid && !out_ready, "input stalled with the output free")

    `ASSERT_IMPLIES(a_speed_range, clk, rst_n, out_valid, (left_speed >= -8'sd100) && (left_speed <= 8'sd100) && (right_speed >= -8'sd100) && (right_speed <= 8'sd100), "speed out of range")

endmodule

bind differential_drive_slew_failsafe ddsf_checker u_ddsf_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .left_speed  (left_speed),
    .right_speed (right_speed),
    .changed     (changed),
    .stopped     (stopped)
);

// ===== tb/sv/drive_mix_checker.sv =====
module drive_mix_checker
(
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 cfg_we,
    input  logic [ddsf_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [ddsf_pkg::CFG_DATA_W-1:0]      cfg_data,

    input  logic                                 in_valid,
    input  logic                                 in_ready,
    input  logic                                 kind,
    input  logic signed [ddsf_pkg::FIELD_W-1:0]  steer,
    input  logic signed [ddsf_pkg::FIELD_W-1:0]  forward,
    input  logic signed [ddsf_pkg::FIELD_W-1:0]  throttle,
    input  logic [ddsf_pkg::DEFAULT_TIME_WIDTH-1:0] now_ms,

    input  logic                                 out_valid,
    input  logic                                 out_ready,
    input  logic signed [7:0]                    left_speed,
    input  logic signed [7:0]                    right_speed,
    input  logic                                 changed,
    input  logic                                 stopped,

    output int                                   mismatches,
    output int                                   outstanding
);

    import ddsf_pkg::*;

    typedef struct packed
    {
        logic signed [7:0] left;
        logic signed [7:0] right;
        logic              moved;
        logic              halted;
    } speed_result_t;

    speed_result_t expected_speeds[$];

    // shadow of the block state and registers
    int                            left_cmd;
    int                            right_cmd;
    int                            left_out;
    int                            right_out;
    logic [DEFAULT_TIME_WIDTH-1:0] last_drive;
    logic                          failsafe;
    logic [6:0]                    deadband;
    logic [7:0]                    step_run;
    logic [7:0]                    step_stop;
    logic [15:0]                   timeout_ms;

    function automatic int clip(input int v, input int lo, input int hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic int deadbanded(input int v);
        int mag;
        mag = (v < 0) ? -v : v;
        return (mag < int'(deadband)) ? 0 : v;
    endfunction

    function automatic int slew_toward(input int cur, input int tgt);
        int d;
        int step;
        d = tgt - cur;
        step = (tgt == 0) ? int'(step_stop) : int'(step_run);
        if (d > step)
            d = step;
        if (d < -step)
            d = -step;
        return cur + d;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] check failed: %s", $time, msg);
        mismatches = mismatches + 1;
    endtask

    task automatic predict_drive_word();
        int x;
        int y;
        int th;
        int l;
        int r;
        int nl;
        int nr;
        logic [DEFAULT_TIME_WIDTH-1:0] elapsed;
        speed_result_t res;
        res.moved = 1'b0;
        if (kind_t'(kind) == KIND_DRIVE)
        begin
            x = clip(int'(steer), -CMD_MAX, CMD_MAX);
            y = clip(int'(forward), -CMD_MAX, CMD_MAX);
            th = clip(int'(throttle), 0, THROTTLE_MAX);
            l = clip(y + x, -CMD_MAX, CMD_MAX);
            r = clip(y - x, -CMD_MAX, CMD_MAX);
            // int division truncates toward zero
            left_cmd = (l * th) / 100;
            right_cmd = (r * th) / 100;
            last_drive = now_ms;
            failsafe = 1'b0;
        end
        else
        begin
            elapsed = now_ms - last_drive;
            if (timeout_ms != 0 && elapsed > DEFAULT_TIME_WIDTH'(timeout_ms))
                failsafe = 1'b1;
            nl = slew_toward(left_out, failsafe ? 0 : deadbanded(left_cmd));
            nr = slew_toward(right_out, failsafe ? 0 : deadbanded(right_cmd));
            res.moved = (nl != left_out) || (nr != right_out);
            left_out = nl;
            right_out = nr;
        end
        res.left = left_out[7:0];
        res.right = right_out[7:0];
        res.halted = failsafe;
        expected_speeds.push_back(res);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        speed_result_t want;
        if (!rst_n)
        begin
            left_cmd = 0;
            right_cmd = 0;
            left_out = 0;
            right_out = 0;
            last_drive = '0;
            failsafe = 1'b0;
            deadband = DEADBAND_RST;
            step_run = SLEW_STEP_RST;
            step_stop = SLEW_STOP_RST;
            timeout_ms = TIMEOUT_RST;
            expected_speeds.delete();
            mismatches = 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (reg_idx_t'(cfg_index))
                    REG_DEADBAND:  deadband = cfg_data[6:0];
                    REG_SLEW_STEP: step_run = cfg_data[7:0];
                    REG_SLEW_STOP: step_stop = cfg_data[7:0];
                    REG_TIMEOUT:   timeout_ms = cfg_data[15:0];
                    default:       ;
                endcase
            end

            if (out_valid && out_ready)
            begin
                if (expected_speeds.size() == 0)
                    report_mismatch($sformatf("result word with nothing expected (left %0d right %0d)",
                                              left_speed, right_speed));
                else
                begin
                    want = expected_speeds.pop_front();
                    if (left_speed !== want.left)
                        report_mismatch($sformatf("left_speed got %0d want %0d",
                                                  left_speed, want.left));
                    if (right_speed !== want.right)
                        report_mismatch($sformatf("right_speed got %0d want %0d",
                                                  right_speed, want.right));
                    if (changed !== want.moved)
                        report_mismatch($sformatf("changed got %b want %b",
                                                  changed, want.moved));
                    if (stopped !== want.halted)
                        report_mismatch($sformatf("stopped got %b want %b",
                                                  stopped, want.halted));
                end
            end

            if (in_valid && in_ready)
                predict_drive_word();

            outstanding <= expected_speeds.size();
        end
    end

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;

    import ddsf_pkg::*;

    localparam int TW              = DEFAULT_TIME_WIDTH;
    localparam int PHASES          = 8;
    localparam int WORDS_PER_PHASE = 80;
    localparam int HOLD_CYCLES     = 40;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int SETTLE_CYCLES   = 8;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;

    logic                       cfg_we;
    logic [CFG_INDEX_W-1:0]     cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_data;

    logic                       in_valid;
    logic                       in_ready;
    kind_t                      kind;
    logic signed [FIELD_W-1:0]  steer;
    logic signed [FIELD_W-1:0]  forward;
    logic signed [FIELD_W-1:0]  throttle;
    logic [TW-1:0]              now_ms;

    logic                       out_valid;
    logic                       out_ready;
    logic signed [7:0]          left_speed;
    logic signed [7:0]          right_speed;
    logic                       changed;
    logic                       stopped;

    int                         mismatches;
    int                         outstanding;

    int                         hold_asks = 0;
    int                         hold_seen = 0;
    int                         hold_left = 0;
    int                         rx_stall_pct = 0;
    int                         tx_idle_pct;
    int                         idle_cycles = 0;
    logic [TW-1:0]              last_drive_ms;
    int                         cur_timeout;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    differential_drive_slew_failsafe #(.TIME_WIDTH(TW)) uut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .steer       (steer),
        .forward     (forward),
        .throttle    (throttle),
        .now_ms      (now_ms),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .left_speed  (left_speed),
        .right_speed (right_speed),
        .changed     (changed),
        .stopped     (stopped)
    );

    drive_mix_checker mix_check
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .steer       (steer),
        .forward     (forward),
        .throttle    (throttle),
        .now_ms      (now_ms),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .left_speed  (left_speed),
        .right_speed (right_speed),
        .changed     (changed),
        .stopped     (stopped),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // receiver: long hold-off on request, otherwise random stalls
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_asks != hold_seen)
        begin
            hold_seen <= hold_asks;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // offer one word, wait for it to be taken, then maybe idle a while
    task automatic send(input kind_t k, input logic [15:0] s, input logic [15:0] f,
                        input logic [15:0] t, input logic [TW-1:0] stamp);
        int gap;
        in_valid <= 1'b1;
        kind <= k;
        steer <= s;
        forward <= f;
        throttle <= t;
        now_ms <= stamp;
        if (k == KIND_DRIVE)
            last_drive_ms = stamp;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
        @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    // upper data bits carry junk; the registers keep only their own width
    task automatic apply_setting(input int sel);
        logic [6:0]  db;
        logic [7:0]  st;
        logic [7:0]  sp;
        logic [15:0] tmo;
        case (sel)
            0: begin db = 7'd0;   st = 8'd255; sp = 8'd255; tmo = 16'd0;     end
            1: begin db = 7'd127; st = 8'd0;   sp = 8'd0;   tmo = 16'd65535; end
            2: begin db = 7'd10;  st = 8'd3;   sp = 8'd7;   tmo = 16'd50;    end
            3: begin db = 7'd1;   st = 8'd1;   sp = 8'd20;  tmo = 16'd1;     end
            default: begin db = 7'd0; st = 8'd5; sp = 8'd10; tmo = 16'd500;  end
        endcase
        write_reg(REG_DEADBAND, {9'($urandom()), db});
        write_reg(REG_SLEW_STEP, {8'($urandom()), st});
        write_reg(REG_SLEW_STOP, {8'($urandom()), sp});
        write_reg(REG_TIMEOUT, tmo);
        cfg_we <= 1'b0;
        cur_timeout = tmo;
    endtask

    // drives are followed by runs of ticks; tick stamps cluster around the timeout
    task automatic random_word();
        int span;
        int pick;
        int v_s;
        int v_f;
        int v_t;
        logic [TW-1:0] off;
        span = (cur_timeout == 0) ? 600 : cur_timeout;
        if ($urandom_range(99) < 25)
        begin
            if ($urandom_range(99) < 15)
            begin
                v_s = $urandom();
                v_f = $urandom();
                v_t = $urandom();
            end
            else
            begin
                v_s = $urandom_range(240) - 120;
                v_f = $urandom_range(240) - 120;
                v_t = $urandom_range(130) - 15;
            end
            if ($urandom_range(99) < 20)
                off = $urandom();
            else
                off = last_drive_ms + $urandom_range(span / 2);
            send(KIND_DRIVE, 16'(v_s), 16'(v_f), 16'(v_t), off);
        end
        else
        begin
            pick = $urandom_range(99);
            if (pick < 55)
                off = $urandom_range(span);
            else if (pick < 75)
                off = span - 1 + $urandom_range(2);
            else if (pick < 90)
                off = span + $urandom_range(3000, 1);
            else
                off = $urandom();
            send(KIND_TICK, 16'($urandom()), 16'($urandom()), 16'($urandom()),
                 last_drive_ms + off);
        end
    endtask

    initial
    begin
        int mode;
        cfg_we = 1'b0;
        cfg_index = REG_DEADBAND;
        cfg_data = '0;
        in_valid = 1'b0;
        kind = KIND_DRIVE;
        steer = '0;
        forward = '0;
        throttle = '0;
        now_ms = '0;
        out_ready = 1'b0;
        tx_idle_pct = 0;
        last_drive_ms = '0;
        cur_timeout = TIMEOUT_RST;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words under the reset register values
        send(KIND_DRIVE, 16'sd0, 16'sd100, 16'sd100, 32'd0);
        send(KIND_TICK, 16'sd0, 16'sd0, 16'sd0, 32'd10);
        send(KIND_TICK, 16'sd0, 16'sd0, 16'sd0, 32'd20);
        // clamp at the field extremes
        send(KIND_DRIVE, 16'h7FFF, 16'h8000, 16'h7FFF, 32'd30);
        send(KIND_TICK, 16'sd0, 16'sd0, 16'sd0, 32'd40);
        // negative throttle clamps to zero
        send(KIND_DRIVE, 16'h8000, 16'h7FFF, 16'h8000, 32'd50);
        send(KIND_TICK, 16'sd0, 16'sd0, 16'sd0, 32'd60);
        send(KIND_DRIVE, 16'sd50, 16'sd50, 16'sd33, 32'd70);
        // negative products truncate toward zero
        send(KIND_DRIVE, -16'sd37, -16'sd60, 16'sd77, 32'd80);
        send(KIND_TICK, 16'sd0, 16'sd0, 16'sd0, 32'd90);
        send(KIND_TICK, 16'sd0, 16'sd0, 16'sd0, 32'd100);
        // elapsed equal to the timeout does not trip, one more does
        send(KIND_TICK, 16'sd0, 16'sd0, 16'sd0, 32'd580);
        send(KIND_TICK, 16'sd0, 16'sd0, 16'sd0, 32'd581);
        send(KIND_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        // a drive clears failsafe; the following ticks wrap the stamp
        send(KIND_DRIVE, 16'sd100, -16'sd100, 16'sd100, 32'hFFFF_FFF0);
        send(KIND_TICK, 16'sd0, 16'sd0, 16'sd0, 32'h0000_0100);
        send(KIND_TICK, 16'sd0, 16'sd0, 16'sd0, 32'h0000_01E4);
        send(KIND_TICK, 16'sd0, 16'sd0, 16'sd0, 32'h0000_01E5);
        send(KIND_TICK, 16'h8000, 16'h8000, 16'h8000, 32'h8000_0000);

        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            apply_setting(p % 5);
            mode = p % 4;
            tx_idle_pct = (mode == 1) ? 65 : (mode == 3) ? 22 : 0;
            rx_stall_pct <= (mode == 2) ? 65 : (mode == 3) ? 22 : 0;
            // receiver holds off while words keep coming, so the pipe backs up
            if (mode == 2)
                hold_asks <= hold_asks + 1;
            for (int n = 0; n < WORDS_PER_PHASE; n++)
                random_word();
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/ddsf_pkg.sv
hw/rtl/ddsf_mix.sv
hw/rtl/ddsf_slew.sv
hw/rtl/differential_drive_slew_failsafe.sv
hw/rtl/ddsf_checker.sv
tb/sv/drive_mix_checker.sv
tb/sv/tb_top.sv
